### hw/rtl/qdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdd_pkg: shared types and constants of the quadrature decoder
// Widths, register indexes, action codes and the item and result records.
// ----------------------------------------------------------------------------
package qdd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int POS_BITS   = 16;
  localparam int TIME_BITS  = 32;
  localparam int LIMIT_BITS = 15;
  localparam int CFG_BITS   = 15;
  localparam int MAG_BITS   = POS_BITS + 1;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(2000);

  typedef enum logic {
    CFG_INVERT = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_index_t;

  typedef enum logic {
    ACT_SAMPLE  = 1'b0,
    ACT_MEASURE = 1'b1
  } action_t;

  typedef struct packed {
    action_t                action;
    logic                   chan_a;
    logic                   chan_b;
    logic [TIME_BITS-1:0]   now_time;
  } item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]         position;
    logic signed [POS_BITS-1:0]  delta;
    logic [TIME_BITS-1:0]        elapsed;
    logic                        delta_valid;
    logic                        implausible;
  } result_t;

endpackage

### hw/rtl/qdd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdd_core: x4 edge counter and measurement state
// Steps the count on single-channel edges and forms delta and elapsed time
// on measure requests; state advances on each step enable.
// ----------------------------------------------------------------------------
module qdd_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_en,
  input  qdd_pkg::item_t                  item,
  input  logic                            invert_direction,
  input  logic [qdd_pkg::LIMIT_BITS-1:0]  plausible_limit,
  output qdd_pkg::result_t                result
);

  logic [qdd_pkg::COUNT_BITS-1:0] counter, counter_next;
  logic [qdd_pkg::COUNT_BITS-1:0] last_count;
  logic [qdd_pkg::TIME_BITS-1:0]  last_time;
  logic                           prev_a, prev_b, primed;

  logic                                  eff_a, a_edge, b_edge, up, step;
  logic [qdd_pkg::COUNT_BITS-1:0]        diff;
  logic signed [qdd_pkg::COUNT_BITS-1:0] sdiff;
  logic signed [qdd_pkg::POS_BITS-1:0]   delta16;
  logic [qdd_pkg::MAG_BITS-1:0]          mag;
  logic                                  is_sample, is_delta;

  assign is_sample = (item.action == qdd_pkg::ACT_SAMPLE);
  assign is_delta  = !is_sample && primed;

  assign eff_a  = item.chan_a ^ invert_direction;
  assign a_edge = item.chan_a != prev_a;
  assign b_edge = item.chan_b != prev_b;
  assign step   = a_edge ^ b_edge;
  assign up     = a_edge ? (eff_a != item.chan_b) : (item.chan_b == eff_a);

  always_comb begin
    counter_next = counter;
    if (is_sample && step) begin
      counter_next = up ? counter + 1'b1 : counter - 1'b1;
    end
  end

  assign diff    = counter - last_count;
  assign sdiff   = diff;
  assign delta16 = qdd_pkg::POS_BITS'(sdiff);
  assign mag     = delta16[qdd_pkg::POS_BITS-1]
                   ? qdd_pkg::MAG_BITS'(0) - {1'b1, delta16}
                   : {1'b0, delta16};

  always_comb begin
    result.position    = qdd_pkg::POS_BITS'(counter_next);
    result.delta       = is_delta ? delta16 : '0;
    result.elapsed     = is_delta ? item.now_time - last_time : '0;
    result.delta_valid = is_delta;
    result.implausible = is_delta &&
                         (mag > qdd_pkg::MAG_BITS'(plausible_limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter    <= '0;
      prev_a     <= 1'b0;
      prev_b     <= 1'b0;
      primed     <= 1'b0;
      last_count <= '0;
      last_time  <= '0;
    end else if (step_en) begin
      counter <= counter_next;
      if (is_sample) begin
        prev_a <= item.chan_a;
        prev_b <= item.chan_b;
      end else begin
        primed     <= 1'b1;
        last_count <= counter;
        last_time  <= item.now_time;
      end
    end
  end

endmodule

### hw/rtl/quadrature_decoder_with_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_with_delta: 4x quadrature counter with measured delta
// Counts encoder edges from pin samples and answers measure requests with
// the signed count change and elapsed time since the previous measurement.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid, in_stall, action, chan_a,       | sink
//            | chan_b, now_time                          |
//   out      | out_valid, out_stall, position, delta,    | source
//            | elapsed, delta_valid, implausible         |
//   cfg      | cfg_we, cfg_index, cfg_data               | sink
//
// One item per cycle while in_stall is low; each item passes through the
// input register, then the result register, before its result is
// presented on out.
// Reset clears the count, the measurement state and both valid flags.
// A stall on out holds the result register and backs up into in_stall
// once the input register is also full.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_delta (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic                               chan_a,
  input  logic                               chan_b,
  input  logic [qdd_pkg::TIME_BITS-1:0]      now_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qdd_pkg::POS_BITS-1:0]       position,
  output logic signed [qdd_pkg::POS_BITS-1:0] delta,
  output logic [qdd_pkg::TIME_BITS-1:0]      elapsed,
  output logic                               delta_valid,
  output logic                               implausible,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [qdd_pkg::CFG_BITS-1:0]       cfg_data
);

  logic                           invert_direction;
  logic [qdd_pkg::LIMIT_BITS-1:0] plausible_limit;

  logic             s1_valid;
  qdd_pkg::item_t   s1_item;
  logic             advance;
  logic             s1_move;
  qdd_pkg::result_t core_result;
  qdd_pkg::result_t out_result;

  assign advance  = !out_valid || !out_stall;
  assign s1_move  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_direction <= 1'b0;
      plausible_limit  <= qdd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (qdd_pkg::cfg_index_t'(cfg_index))
        qdd_pkg::CFG_INVERT: invert_direction <= cfg_data[0];
        qdd_pkg::CFG_LIMIT:  plausible_limit  <= cfg_data[qdd_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.action   <= qdd_pkg::action_t'(action);
      s1_item.chan_a   <= chan_a;
      s1_item.chan_b   <= chan_b;
      s1_item.now_time <= now_time;
    end
  end

  qdd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step_en          (s1_move),
    .item             (s1_item),
    .invert_direction (invert_direction),
    .plausible_limit  (plausible_limit),
    .result           (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_result <= core_result;
    end
  end

  assign position    = out_result.position;
  assign delta       = out_result.delta;
  assign elapsed     = out_result.elapsed;
  assign delta_valid = out_result.delta_valid;
  assign implausible = out_result.implausible;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

  a_flag_needs_delta: assert property (@(posedge clk) disable iff (rst)
    out_valid && implausible |-> delta_valid)
    else $error("implausible flag without a delta");

  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !delta_valid |-> delta == '0 && elapsed == '0)
    else $error("delta fields set without a delta");

endmodule
